[rtl/ffsd_pkg.sv]
// Shared types, request and status codes, and pointer arithmetic for the search-and-delete FIFO.
// No dependencies.
package ffsd_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_POP    = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_FIND   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic start;
		logic del;
	} walk_cmd_t;

	typedef struct packed {
		logic done;
		logic hit;
	} walk_sts_t;

	// base + off modulo depth, with base < depth and off <= depth
	function automatic logic [31:0] ffsd_wrap(input logic [31:0] base, input logic [31:0] off,
		input logic [31:0] depth);
		logic [32:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= {1'b0, depth}) begin
			sum = sum - {1'b0, depth};
		end
		return sum[31:0];
	endfunction

endpackage

[rtl/fifo_with_search_and_delete.sv]
// Search-and-delete FIFO top level: request sequencer, entry RAM and walker.
// A request goes from dispatch straight to finish for push and on an empty queue, through pop read for pop,
// and through the walker, which reads one RAM entry per cycle, for delete and find.
// One request at a time; the next beat is taken once the result is loaded in the output register.
// Reset (arst_n low) empties the queue; RAM contents are not cleared. Depends on ffsd_pkg.
module fifo_with_search_and_delete
	import ffsd_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] popped_value,
	output logic               found,
	output logic [4:0]         entry_count,
	output logic               is_empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_POPRD,
		S_WALK,
		S_FINISH
	} state_t;

	state_t                state_q;
	req_t                  kind_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic [AW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	status_t               res_status_q;
	logic [31:0]           res_popped_q;
	logic                  res_found_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic [31:0]           popped_q;
	logic                  found_q;
	logic [4:0]            entry_count_q;
	logic                  is_empty_q;

	logic [AW-1:0]         tail_addr;
	logic [AW-1:0]         head_next;
	logic                  is_full;
	logic                  is_none;
	logic                  push_we;
	logic                  pop_re;
	logic                  out_load;
	logic [31:0]           count_ext;
	logic [63:0]           popped_ext;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	walk_cmd_t             walk_cmd;
	walk_sts_t             walk_sts;
	logic                  walk_re;
	logic [AW-1:0]         walk_raddr;
	logic                  walk_we;
	logic [AW-1:0]         walk_waddr;
	logic [DATA_WIDTH-1:0] walk_wdata;
	logic [CW-1:0]         walk_kept;

	assign tail_addr = AW'(ffsd_wrap(32'(head_q), 32'(count_q), 32'(DEPTH)));
	assign head_next = AW'(ffsd_wrap(32'(head_q), 32'd1, 32'(DEPTH)));
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_none   = (count_q == '0);
	assign push_we   = (state_q == S_DISPATCH) && (kind_q == REQ_PUSH) && !is_full;
	assign pop_re    = (state_q == S_DISPATCH) && (kind_q == REQ_POP) && !is_none;

	assign walk_cmd.start = (state_q == S_DISPATCH) && !is_none &&
		((kind_q == REQ_DELETE) || (kind_q == REQ_FIND));
	assign walk_cmd.del   = (kind_q == REQ_DELETE);

	assign ram_we    = push_we | walk_we;
	assign ram_waddr = push_we ? tail_addr : walk_waddr;
	assign ram_wdata = push_we ? key_q : walk_wdata;
	assign ram_re    = pop_re | walk_re;
	assign ram_raddr = pop_re ? head_q : walk_raddr;

	assign count_ext  = 32'(count_q);
	assign popped_ext = 64'(ram_rdata);
	assign out_load   = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign found        = found_q;
	assign entry_count  = entry_count_q;
	assign is_empty     = is_empty_q;

	ffsd_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ffsd_walk #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_walk (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (walk_cmd),
		.head  (head_q),
		.count (count_q),
		.key   (key_q),
		.rdata (ram_rdata),
		.re    (walk_re),
		.raddr (walk_raddr),
		.we    (walk_we),
		.waddr (walk_waddr),
		.wdata (walk_wdata),
		.sts   (walk_sts),
		.kept  (walk_kept)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			kind_q        <= REQ_PUSH;
			key_q         <= '0;
			head_q        <= '0;
			count_q       <= '0;
			res_status_q  <= ST_OK;
			res_popped_q  <= '0;
			res_found_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_OK;
			popped_q      <= '0;
			found_q       <= 1'b0;
			entry_count_q <= '0;
			is_empty_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= req_t'(req_type);
						key_q   <= DATA_WIDTH'($unsigned(value));
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					res_popped_q <= '0;
					res_found_q  <= 1'b0;
					res_status_q <= ST_OK;
					case (kind_q)
						REQ_PUSH: begin
							if (is_full) begin
								res_status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
							state_q <= S_FINISH;
						end
						REQ_POP: begin
							if (is_none) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_FINISH;
							end else begin
								state_q <= S_POPRD;
							end
						end
						REQ_DELETE: begin
							if (is_none) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_FINISH;
							end else begin
								state_q <= S_WALK;
							end
						end
						default: begin
							state_q <= is_none ? S_FINISH : S_WALK;
						end
					endcase
				end
				S_POPRD: begin
					res_popped_q <= popped_ext[31:0];
					head_q       <= head_next;
					count_q      <= count_q - CW'(1);
					state_q      <= S_FINISH;
				end
				S_WALK: begin
					if (walk_sts.done) begin
						if (kind_q == REQ_DELETE) begin
							count_q <= walk_kept;
						end else begin
							res_found_q <= walk_sts.hit;
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_load) begin
						status_q      <= res_status_q;
						popped_q      <= res_popped_q;
						found_q       <= res_found_q;
						entry_count_q <= count_ext[4:0];
						is_empty_q    <= is_none;
						out_valid_q   <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");
	a_load_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result loaded outside finish");
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_we && walk_we))
		else $error("push and walker write RAM together");
`endif

endmodule

[rtl/ffsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/ffsd_walk.sv]
// Entry walker: steps through stored entries with one shared comparator, flags a match
// and compacts the queue on delete. Depends on ffsd_pkg.
module ffsd_walk
	import ffsd_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  walk_cmd_t                      cmd,
	input  logic [$clog2(DEPTH)-1:0]       head,
	input  logic [$clog2(DEPTH+1)-1:0]     count,
	input  logic [DATA_WIDTH-1:0]          key,
	input  logic [DATA_WIDTH-1:0]          rdata,
	output logic                           re,
	output logic [$clog2(DEPTH)-1:0]       raddr,
	output logic                           we,
	output logic [$clog2(DEPTH)-1:0]       waddr,
	output logic [DATA_WIDTH-1:0]          wdata,
	output walk_sts_t                      sts,
	output logic [$clog2(DEPTH+1)-1:0]     kept
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic          running_q;
	logic          del_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] kept_q;
	logic          hit_q;
	logic          pend_s1;
	logic          match;
	logic          done;

	assign re    = running_q && (rd_idx_q < count);
	assign raddr = AW'(ffsd_wrap(32'(head), 32'(rd_idx_q), 32'(DEPTH)));
	assign match = pend_s1 && (rdata == key);
	assign we    = pend_s1 && del_q && (rdata != key);
	assign waddr = AW'(ffsd_wrap(32'(head), 32'(kept_q), 32'(DEPTH)));
	assign wdata = rdata;
	assign done  = running_q && (rd_idx_q == count) && !pend_s1;

	assign sts.done = done;
	assign sts.hit  = hit_q;
	assign kept     = kept_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			del_q     <= 1'b0;
			rd_idx_q  <= '0;
			kept_q    <= '0;
			hit_q     <= 1'b0;
			pend_s1   <= 1'b0;
		end else if (cmd.start) begin
			running_q <= 1'b1;
			del_q     <= cmd.del;
			rd_idx_q  <= '0;
			kept_q    <= '0;
			hit_q     <= 1'b0;
			pend_s1   <= 1'b0;
		end else begin
			pend_s1 <= re;
			if (re) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (match) begin
				hit_q <= 1'b1;
			end
			if (we) begin
				kept_q <= kept_q + CW'(1);
			end
			if (done) begin
				running_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_wr_only_del: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> del_q && running_q)
		else $error("walker write outside delete");
	a_kept_le_idx: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= rd_idx_q)
		else $error("kept count ahead of read index");
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		done && !cmd.start |=> !running_q)
		else $error("walker still running after done");
`endif

endmodule

[verif/tb.sv]
// Testbench for the search-and-delete FIFO: directed and random requests against a queue predictor.
// Every result beat is checked field by field, under varying sender and receiver stalls.
// Depends on ffsd_pkg and fifo_with_search_and_delete.
`timescale 1ns / 100ps

module tb
	import ffsd_pkg::*;
();

	localparam int QDEPTH      = DEPTH_DEF;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		status_t     status;
		logic [31:0] popped;
		logic        hit;
		logic [4:0]  count;
		logic        empty;
	} result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         req_type = REQ_PUSH;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] popped_value;
	logic               found;
	logic [4:0]         entry_count;
	logic               is_empty;

	logic [31:0] queue_model[$];
	result_t     pending_results[$];
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;

	fifo_with_search_and_delete uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.popped_value (popped_value),
		.found        (found),
		.entry_count  (entry_count),
		.is_empty     (is_empty)
	);

	always #4 clk = ~clk;

	// advance the queue model by one request and return the response it gives
	function automatic result_t apply_request(input req_t kind, input logic [31:0] key);
		result_t     r;
		logic [31:0] kept[$];
		r.status = ST_OK;
		r.popped = '0;
		r.hit    = 1'b0;
		case (kind)
			REQ_PUSH: begin
				if (queue_model.size() >= QDEPTH)
					r.status = ST_FULL;
				else
					queue_model.push_back(key);
			end
			REQ_POP: begin
				if (queue_model.size() == 0)
					r.status = ST_EMPTY;
				else
					r.popped = queue_model.pop_front();
			end
			REQ_DELETE: begin
				if (queue_model.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					foreach (queue_model[i])
						if (queue_model[i] != key)
							kept.push_back(queue_model[i]);
					queue_model = kept;
				end
			end
			default: begin
				foreach (queue_model[i])
					if (queue_model[i] == key)
						r.hit = 1'b1;
			end
		endcase
		r.count = 5'(queue_model.size());
		r.empty = (queue_model.size() == 0);
		return r;
	endfunction

	task automatic send_request(input req_t kind, input logic [31:0] key);
		int gap;
		gap = 0;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		value    <= key;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(apply_request(kind, key));
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3, 4, 5, 6: return $urandom_range(0, 5);
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t pick_request(input bit filling);
		int roll;
		roll = $urandom_range(0, 99);
		if (filling)
			return roll < 55 ? REQ_PUSH : roll < 70 ? REQ_POP : roll < 82 ? REQ_DELETE : REQ_FIND;
		return roll < 20 ? REQ_PUSH : roll < 55 ? REQ_POP : roll < 75 ? REQ_DELETE : REQ_FIND;
	endfunction

	task automatic test_empty_queue();
		send_request(REQ_POP, 32'h0000_0000);
		send_request(REQ_DELETE, 32'hFFFF_FFFF);
		send_request(REQ_FIND, 32'h8000_0000);
	endtask

	task automatic test_fill_and_overflow();
		logic [31:0] key;
		for (int i = 0; i < QDEPTH; i++) begin
			case (i % 4)
				0: key = 32'h8000_0000;
				1: key = 32'h7FFF_FFFF;
				2: key = 32'hFFFF_FFFF;
				default: key = 32'h0000_0000;
			endcase
			send_request(REQ_PUSH, key);
		end
		send_request(REQ_PUSH, 32'h5555_AAAA);
	endtask

	// find, pop and delete; deleting every remaining value in turn makes the last delete empty the queue
	task automatic test_search_and_delete();
		send_request(REQ_FIND, 32'h7FFF_FFFF);
		send_request(REQ_FIND, 32'h0000_0005);
		send_request(REQ_DELETE, 32'h0000_0005);
		send_request(REQ_POP, 32'h1234_5678);
		send_request(REQ_DELETE, 32'h8000_0000);
		send_request(REQ_DELETE, 32'h7FFF_FFFF);
		send_request(REQ_DELETE, 32'hFFFF_FFFF);
		send_request(REQ_DELETE, 32'h0000_0000);
	endtask

	// alternate push-heavy and pop-heavy stretches to sweep the fill level
	task automatic test_random_traffic(input int n);
		for (int i = 0; i < n; i++)
			send_request(pick_request((i / 24) % 2 == 0), pick_value());
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no request outstanding");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatch_count++;
				end
				if (popped_value !== want.popped) begin
					$error("popped_value: expected %0d, got %0d", $signed(want.popped),
						popped_value);
					mismatch_count++;
				end
				if (found !== want.hit) begin
					$error("found: expected %0b, got %0b", want.hit, found);
					mismatch_count++;
				end
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, entry_count);
					mismatch_count++;
				end
				if (is_empty !== want.empty) begin
					$error("is_empty: expected %0b, got %0b", want.empty, is_empty);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		tx_idle_pct = 30;
		rx_idle_pct = 85;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_fill_and_overflow();
		test_search_and_delete();
		test_random_traffic(130);

		tx_idle_pct = 85;
		rx_idle_pct = 30;
		test_random_traffic(130);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(140);

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (QDEPTH + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

[fifo_with_search_and_delete.f]
rtl/ffsd_pkg.sv
rtl/ffsd_ram.sv
rtl/ffsd_walk.sv
rtl/fifo_with_search_and_delete.sv
verif/tb.sv
